FILE: hw/rtl/sdt_pkg.sv
package sdt_pkg;

  localparam int unsigned PIX_W  = 16;
  localparam int unsigned BASE_W = 24;
  localparam int unsigned FACT_W = 8;
  localparam int unsigned TOL_W  = 12;
  localparam int unsigned NUM_W  = PIX_W + BASE_W;
  localparam int unsigned LIM_W  = FACT_W + BASE_W;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 24;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FOCAL_X    = 3'd0,
    CFG_CENTER_X   = 3'd1,
    CFG_CENTER_Y   = 3'd2,
    CFG_BASELINE   = 3'd3,
    CFG_LIMIT_FACT = 3'd4,
    CFG_ROW_TOL    = 3'd5
  } sdt_cfg_e;

  typedef struct packed {
    logic [PIX_W-1:0]  focal_x;
    logic [PIX_W-1:0]  center_x;
    logic [PIX_W-1:0]  center_y;
    logic [BASE_W-1:0] baseline;
    logic [FACT_W-1:0] limit_fact;
    logic [TOL_W-1:0]  row_tol;
  } sdt_cfg_t;

  typedef struct packed {
    logic              zero;
    logic              row_ok;
    logic              neg_x;
    logic              neg_y;
    logic [LIM_W-1:0]  limit;
    logic [PIX_W-1:0]  den;
    logic [NUM_W-1:0]  num_x;
    logic [NUM_W-1:0]  num_y;
    logic [NUM_W-1:0]  num_z;
    logic [PIX_W-1:0]  rem_x;
    logic [PIX_W-1:0]  rem_y;
    logic [PIX_W-1:0]  rem_z;
  } sdt_div_t;

endpackage

FILE: hw/rtl/sdt_front.sv
module sdt_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sdt_pkg::sdt_cfg_t         cfg_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [sdt_pkg::PIX_W-1:0] left_x_i,
  input  logic [sdt_pkg::PIX_W-1:0] left_y_i,
  input  logic [sdt_pkg::PIX_W-1:0] right_x_i,
  input  logic [sdt_pkg::PIX_W-1:0] right_y_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output sdt_pkg::sdt_div_t         data_o
);
  import sdt_pkg::*;

  // stage 1: differences and row check
  logic             v1_q;
  logic             zero_q, row_ok_q, neg_x_q, neg_y_q;
  logic [PIX_W-1:0] den_q, mag_x_q, mag_y_q;
  logic             rdy1;

  logic [PIX_W:0]   dx, dy, ex, ey;
  logic [PIX_W-1:0] d_abs, dy_abs;

  always_comb begin
    dx     = {1'b0, left_x_i} - {1'b0, right_x_i};
    dy     = {1'b0, left_y_i} - {1'b0, right_y_i};
    ex     = {1'b0, left_x_i} - {1'b0, cfg_i.center_x};
    ey     = {1'b0, left_y_i} - {1'b0, cfg_i.center_y};
    d_abs  = dx[PIX_W] ? PIX_W'(-dx) : dx[PIX_W-1:0];
    dy_abs = dy[PIX_W] ? PIX_W'(-dy) : dy[PIX_W-1:0];
  end

  // stage 2: products
  logic     v2_q;
  sdt_div_t d2_q;

  logic [NUM_W-1:0] prod_x, prod_y, prod_z;
  logic [LIM_W-1:0] prod_lim;

  always_comb begin
    prod_x   = {{(NUM_W-PIX_W){1'b0}}, mag_x_q} *
               {{(NUM_W-BASE_W){1'b0}}, cfg_i.baseline};
    prod_y   = {{(NUM_W-PIX_W){1'b0}}, mag_y_q} *
               {{(NUM_W-BASE_W){1'b0}}, cfg_i.baseline};
    prod_z   = {{(NUM_W-PIX_W){1'b0}}, cfg_i.focal_x} *
               {{(NUM_W-BASE_W){1'b0}}, cfg_i.baseline};
    prod_lim = {{(LIM_W-FACT_W){1'b0}}, cfg_i.limit_fact} *
               {{(LIM_W-BASE_W){1'b0}}, cfg_i.baseline};
  end

  assign rdy1    = !v2_q || ready_i;
  assign ready_o = !v1_q || rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready_o) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      zero_q   <= (d_abs == '0);
      row_ok_q <= ({{(PIX_W-TOL_W){1'b0}}, cfg_i.row_tol} > dy_abs);
      neg_x_q  <= ex[PIX_W];
      neg_y_q  <= ey[PIX_W];
      den_q    <= d_abs;
      mag_x_q  <= ex[PIX_W] ? PIX_W'(-ex) : ex[PIX_W-1:0];
      mag_y_q  <= ey[PIX_W] ? PIX_W'(-ey) : ey[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy1) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && v1_q) begin
      d2_q.zero   <= zero_q;
      d2_q.row_ok <= row_ok_q;
      d2_q.neg_x  <= neg_x_q;
      d2_q.neg_y  <= neg_y_q;
      d2_q.limit  <= prod_lim;
      d2_q.den    <= den_q;
      d2_q.num_x  <= prod_x;
      d2_q.num_y  <= prod_y;
      d2_q.num_z  <= prod_z;
      d2_q.rem_x  <= '0;
      d2_q.rem_y  <= '0;
      d2_q.rem_z  <= '0;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = d2_q;

endmodule

FILE: hw/rtl/sdt_div_stage.sv
module sdt_div_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sdt_pkg::sdt_div_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output sdt_pkg::sdt_div_t data_o
);
  import sdt_pkg::*;

  logic     v_q;
  sdt_div_t d_q;
  sdt_div_t d_d;

  // one quotient bit per lane, restoring step
  function automatic logic [PIX_W+NUM_W-1:0] step(input logic [PIX_W-1:0] rem,
                                                  input logic [NUM_W-1:0] num,
                                                  input logic [PIX_W-1:0] den);
    logic [PIX_W:0]   sh;
    logic             ge;
    logic [PIX_W:0]   nr;
    sh = {rem, num[NUM_W-1]};
    ge = (sh >= {1'b0, den});
    nr = ge ? (sh - {1'b0, den}) : sh;
    return {nr[PIX_W-1:0], num[NUM_W-2:0], ge};
  endfunction

  always_comb begin
    d_d = data_i;
    {d_d.rem_x, d_d.num_x} = step(data_i.rem_x, data_i.num_x, data_i.den);
    {d_d.rem_y, d_d.num_y} = step(data_i.rem_y, data_i.num_y, data_i.den);
    {d_d.rem_z, d_d.num_z} = step(data_i.rem_z, data_i.num_z, data_i.den);
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

FILE: hw/rtl/sdt_back.sv
module sdt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sdt_pkg::sdt_div_t data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              keep_o,
  output logic              zero_disparity_o,
  output logic              saturated_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic [30:0]       point_z_o
);
  import sdt_pkg::*;

  function automatic logic [32:0] sat_s(input logic neg, input logic [NUM_W-1:0] q);
    logic        clip;
    logic [31:0] mag;
    if (neg) begin
      clip = (|q[NUM_W-1:32]) || (q[31] && (|q[30:0]));
      mag  = clip ? 32'h8000_0000 : q[31:0];
      return {clip, 32'(-mag)};
    end else begin
      clip = |q[NUM_W-1:31];
      return {clip, clip ? 32'h7FFF_FFFF : {1'b0, q[30:0]}};
    end
  endfunction

  logic [32:0] sx, sy;
  logic        clip_z;
  logic        v_q;

  always_comb begin
    sx     = sat_s(data_i.neg_x, data_i.num_x);
    sy     = sat_s(data_i.neg_y, data_i.num_y);
    clip_z = |data_i.num_z[NUM_W-1:31];
  end

  assign ready_o = !v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      if (data_i.zero) begin
        keep_o           <= 1'b0;
        zero_disparity_o <= 1'b1;
        saturated_o      <= 1'b0;
        point_x_o        <= '0;
        point_y_o        <= '0;
        point_z_o        <= '0;
      end else begin
        // depth test on the unclipped quotient
        keep_o           <= data_i.row_ok &&
                            (data_i.num_z < {{(NUM_W-LIM_W){1'b0}}, data_i.limit});
        zero_disparity_o <= 1'b0;
        saturated_o      <= sx[32] || sy[32] || clip_z;
        point_x_o        <= sx[31:0];
        point_y_o        <= sy[31:0];
        point_z_o        <= clip_z ? 31'h7FFF_FFFF : data_i.num_z[30:0];
      end
    end
  end

  assign out_valid_o = v_q;

endmodule

FILE: hw/rtl/stereo_disparity_triangulation.sv
// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o  left_x, left_y, right_x, right_y
// out       output     out_valid_o/out_stall_i keep, flags, point_x/y/z
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one item per cycle while the output is not stalled; two front stages (differences,
// products), one restoring quotient bit per stage over 40 stages, output reg
// each stage holds only while its successor is full, so bubbles close up
// reset clears all valid bits and loads the default registers
module stereo_disparity_triangulation (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sdt_pkg::CFG_AW-1:0] cfg_index_i,
  input  logic [sdt_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [sdt_pkg::PIX_W-1:0]  left_x_i,
  input  logic [sdt_pkg::PIX_W-1:0]  left_y_i,
  input  logic [sdt_pkg::PIX_W-1:0]  right_x_i,
  input  logic [sdt_pkg::PIX_W-1:0]  right_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       keep_o,
  output logic                       zero_disparity_o,
  output logic                       saturated_o,
  output logic signed [31:0]         point_x_o,
  output logic signed [31:0]         point_y_o,
  output logic [30:0]                point_z_o
);
  import sdt_pkg::*;

  sdt_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal_x    <= PIX_W'(11200);
      cfg_q.center_x   <= PIX_W'(9600);
      cfg_q.center_y   <= PIX_W'(2880);
      cfg_q.baseline   <= BASE_W'(32768);
      cfg_q.limit_fact <= FACT_W'(45);
      cfg_q.row_tol    <= TOL_W'(64);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FOCAL_X:    cfg_q.focal_x    <= cfg_data_i[PIX_W-1:0];
        CFG_CENTER_X:   cfg_q.center_x   <= cfg_data_i[PIX_W-1:0];
        CFG_CENTER_Y:   cfg_q.center_y   <= cfg_data_i[PIX_W-1:0];
        CFG_BASELINE:   cfg_q.baseline   <= cfg_data_i[BASE_W-1:0];
        CFG_LIMIT_FACT: cfg_q.limit_fact <= cfg_data_i[FACT_W-1:0];
        CFG_ROW_TOL:    cfg_q.row_tol    <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  logic     v   [NUM_W+1];
  logic     rdy [NUM_W+2];
  sdt_div_t dat [NUM_W+1];
  logic     front_ready;

  sdt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (in_valid_i),
    .ready_o   (front_ready),
    .left_x_i  (left_x_i),
    .left_y_i  (left_y_i),
    .right_x_i (right_x_i),
    .right_y_i (right_y_i),
    .valid_o   (v[0]),
    .ready_i   (rdy[1]),
    .data_o    (dat[0])
  );

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    sdt_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[k]),
      .ready_o (rdy[k+1]),
      .data_i  (dat[k]),
      .valid_o (v[k+1]),
      .ready_i (rdy[k+2]),
      .data_o  (dat[k+1])
    );
  end

  assign rdy[0]     = front_ready;
  assign in_stall_o = !rdy[0];

  sdt_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (v[NUM_W]),
    .ready_o          (rdy[NUM_W+1]),
    .data_i           (dat[NUM_W]),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .keep_o           (keep_o),
    .zero_disparity_o (zero_disparity_o),
    .saturated_o      (saturated_o),
    .point_x_o        (point_x_o),
    .point_y_o        (point_y_o),
    .point_z_o        (point_z_o)
  );

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_disparity_o |->
      !keep_o && !saturated_o && point_x_o == 0 && point_y_o == 0 && point_z_o == 0)
    else $error("zero disparity item carries nonzero fields");

  a_keep_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && keep_o |-> !zero_disparity_o)
    else $error("kept item flagged as zero disparity");

  a_front_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

endmodule

FILE: dv/stereo_disparity_triangulation_checker.sv
`timescale 1ns / 100ps

module stereo_disparity_triangulation_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [sdt_pkg::CFG_AW-1:0] cfg_index_i,
  input  logic [sdt_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [15:0]                left_x_i,
  input  logic [15:0]                left_y_i,
  input  logic [15:0]                right_x_i,
  input  logic [15:0]                right_y_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       keep_i,
  input  logic                       zero_disparity_i,
  input  logic                       saturated_i,
  input  logic signed [31:0]         point_x_i,
  input  logic signed [31:0]         point_y_i,
  input  logic [30:0]                point_z_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import sdt_pkg::*;

  typedef struct packed {
    logic        keep;
    logic        zero_disp;
    logic        sat;
    logic [31:0] px;
    logic [31:0] py;
    logic [30:0] pz;
  } point_t;

  point_t    point_q[$];
  sdt_cfg_t  cam;

  assign pending_o = point_q.size();

  function automatic logic [31:0] clip_div(input longint num, input longint den,
                                           inout logic sat);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    if (num < 0) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        q = 64'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      q = 64'h7FFF_FFFF;
    end
    return 32'(q);
  endfunction

  function automatic point_t triangulate(input logic [15:0] lx, ly, rx, ry);
    point_t  r;
    longint  d;
    longint  dy;
    longint  zq;
    longint  lim;
    logic    sat;
    r = '0;
    sat = 1'b0;
    d = (lx > rx) ? lx - rx : rx - lx;
    dy = (ly > ry) ? ly - ry : ry - ly;
    if (d == 0) begin
      r.zero_disp = 1'b1;
      return r;
    end
    r.px = clip_div((longint'(lx) - longint'(cam.center_x)) * longint'(cam.baseline), d, sat);
    r.py = clip_div((longint'(ly) - longint'(cam.center_y)) * longint'(cam.baseline), d, sat);
    zq = (longint'(cam.baseline) * longint'(cam.focal_x)) / d;
    if (zq > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      r.pz = 31'h7FFF_FFFF;
    end else begin
      r.pz = 31'(zq);
    end
    lim = longint'(cam.limit_fact) * longint'(cam.baseline);
    r.keep = (zq < lim) && (dy < longint'(cam.row_tol));
    r.sat = sat;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    point_t exp_pt;
    if (!rst_ni) begin
      cam.focal_x <= 16'd11200;
      cam.center_x <= 16'd9600;
      cam.center_y <= 16'd2880;
      cam.baseline <= 24'd32768;
      cam.limit_fact <= 8'd45;
      cam.row_tol <= 12'd64;
      point_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FOCAL_X:    cam.focal_x <= cfg_data_i[15:0];
          CFG_CENTER_X:   cam.center_x <= cfg_data_i[15:0];
          CFG_CENTER_Y:   cam.center_y <= cfg_data_i[15:0];
          CFG_BASELINE:   cam.baseline <= cfg_data_i;
          CFG_LIMIT_FACT: cam.limit_fact <= cfg_data_i[7:0];
          CFG_ROW_TOL:    cam.row_tol <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        point_q.insert(point_q.size(),
                       triangulate(left_x_i, left_y_i, right_x_i, right_y_i));
      if (out_valid_i && !out_stall_i) begin
        if (point_q.size() == 0) begin
          $error("unexpected item on output");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_pt = point_q.pop_front();
          if (exp_pt.keep !== keep_i || exp_pt.zero_disp !== zero_disparity_i ||
              exp_pt.sat !== saturated_i || exp_pt.px !== point_x_i ||
              exp_pt.py !== point_y_i || exp_pt.pz !== point_z_i) begin
            fail_count_o <= fail_count_o + 1;
            if (exp_pt.keep !== keep_i)
              $error("keep exp %0d got %0d", exp_pt.keep, keep_i);
            if (exp_pt.zero_disp !== zero_disparity_i)
              $error("zero_disparity exp %0d got %0d", exp_pt.zero_disp, zero_disparity_i);
            if (exp_pt.sat !== saturated_i)
              $error("saturated exp %0d got %0d", exp_pt.sat, saturated_i);
            if (exp_pt.px !== point_x_i)
              $error("point_x exp %0d got %0d", $signed(exp_pt.px), point_x_i);
            if (exp_pt.py !== point_y_i)
              $error("point_y exp %0d got %0d", $signed(exp_pt.py), point_y_i);
            if (exp_pt.pz !== point_z_i)
              $error("point_z exp %0d got %0d", exp_pt.pz, point_z_i);
          end
        end
      end
    end
  end

endmodule

FILE: dv/stereo_disparity_triangulation_tb.sv
`timescale 1ns / 100ps

module stereo_disparity_triangulation_tb;
  import sdt_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int LATENCY    = 43;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_AW-1:0]   cfg_index_i;
  logic [CFG_DW-1:0]   cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [15:0]         left_x_i;
  logic [15:0]         left_y_i;
  logic [15:0]         right_x_i;
  logic [15:0]         right_y_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                keep_o;
  logic                zero_disparity_o;
  logic                saturated_o;
  logic signed [31:0]  point_x_o;
  logic signed [31:0]  point_y_o;
  logic [30:0]         point_z_o;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles;
  int                  hold_off;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  stereo_disparity_triangulation u_top (.*);

  stereo_disparity_triangulation_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .left_x_i, .left_y_i, .right_x_i, .right_y_i,
    .out_valid_i(out_valid_o), .out_stall_i, .keep_i(keep_o),
    .zero_disparity_i(zero_disparity_o), .saturated_i(saturated_o),
    .point_x_i(point_x_o), .point_y_i(point_y_o), .point_z_i(point_z_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 60);
  endfunction

  task automatic write_reg(input sdt_cfg_e idx, input int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pair(input logic [15:0] lx, ly, rx, ry);
    in_valid_i <= 1'b1;
    left_x_i <= lx;
    left_y_i <= ly;
    right_x_i <= rx;
    right_y_i <= ry;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  // random pair near a typical rectified match, sometimes zero disparity or fully random
  task automatic rand_pair(input bit gaps);
    logic [15:0] lx, ly, rx, ry;
    int kind;
    kind = $urandom_range(0, 9);
    lx = 16'($urandom());
    ly = 16'($urandom());
    if (kind < 6) begin
      rx = lx - 16'($urandom_range(0, 2000));
      ry = ly + 16'($urandom_range(0, 80)) - 16'd40;
    end else if (kind < 7) begin
      rx = lx;
      ry = 16'($urandom());
    end else begin
      rx = 16'($urandom());
      ry = 16'($urandom());
    end
    send_pair(lx, ly, rx, ry);
    if (gaps) pause(gap_len());
  endtask

  task automatic random_config();
    write_reg(CFG_FOCAL_X, $urandom_range(1, 65535));
    write_reg(CFG_CENTER_X, $urandom_range(0, 65535));
    write_reg(CFG_CENTER_Y, $urandom_range(0, 65535));
    write_reg(CFG_BASELINE, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 'hFFFFFF)
                                                        : $urandom_range(1, 200000));
    write_reg(CFG_LIMIT_FACT, $urandom_range(1, 255));
    write_reg(CFG_ROW_TOL, $urandom_range(0, 4095));
  endtask

  // receiver stalls, with one long hold-off early in the random phase
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    while (hold_off == 0) begin
      @(negedge clk_i);
      n = gap_len();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 20)) @(negedge clk_i);
    end
    out_stall_i <= 1'b1;
    repeat (hold_off) @(negedge clk_i);
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat (gap_len()) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    left_x_i = '0;
    left_y_i = '0;
    right_x_i = '0;
    right_y_i = '0;
    hold_off = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed pairs at reset settings
    send_pair(16'd0, 16'd0, 16'd0, 16'd0);
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    send_pair(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    send_pair(16'd0, 16'd0, 16'hFFFF, 16'd0);
    send_pair(16'd9700, 16'd2900, 16'd9600, 16'd2900);
    send_pair(16'd9700, 16'd2900, 16'd9699, 16'd2963);
    send_pair(16'd9700, 16'd2900, 16'd9699, 16'd2964);
    send_pair(16'd9700, 16'd2900, 16'd9450, 16'd2837);
    drain();

    // extreme settings: large baseline saturates, zero tolerance fails rows
    write_reg(CFG_FOCAL_X, 'hFFFF);
    write_reg(CFG_CENTER_X, 0);
    write_reg(CFG_CENTER_Y, 'hFFFF);
    write_reg(CFG_BASELINE, 'hFFFFFF);
    write_reg(CFG_LIMIT_FACT, 'hFF);
    write_reg(CFG_ROW_TOL, 0);
    send_pair(16'hFFFF, 16'd0, 16'hFFFE, 16'd0);
    send_pair(16'd1, 16'd0, 16'd0, 16'd0);
    send_pair(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    drain();
    write_reg(CFG_FOCAL_X, 1);
    write_reg(CFG_CENTER_X, 'hFFFF);
    write_reg(CFG_CENTER_Y, 0);
    write_reg(CFG_BASELINE, 1);
    write_reg(CFG_LIMIT_FACT, 1);
    write_reg(CFG_ROW_TOL, 'hFFF);
    send_pair(16'd0, 16'hFFFF, 16'd1, 16'd0);
    send_pair(16'd100, 16'd5, 16'd99, 16'd4090);
    send_pair(16'hFFFF, 16'h1234, 16'd0, 16'h0234);
    drain();

    // random phases with a setting change between each
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) random_config();
      if (ph == 1) begin
        hold_off = 400;
        // keep offering through the hold-off so the pipeline backs up
        repeat (150) rand_pair(1'b0);
      end
      repeat (130) rand_pair(1'b1);
      drain();
    end

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: stereo_disparity_triangulation.f
hw/rtl/sdt_pkg.sv
hw/rtl/sdt_front.sv
hw/rtl/sdt_div_stage.sv
hw/rtl/sdt_back.sv
hw/rtl/stereo_disparity_triangulation.sv
dv/stereo_disparity_triangulation_checker.sv
dv/stereo_disparity_triangulation_tb.sv
